// ===== rtl/core/oepo_pkg.sv =====
// Shared constants, types and state codes for the octant extreme point outline block.
`timescale 1ns / 1ps

package oepo_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int SECTORS    = 8;
    localparam int SEC_W      = 3;
    localparam int COORD_W    = 16;
    localparam int PT_W       = 2 * COORD_W;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int SUM_W      = COORD_W + CNT_W;
    localparam int D_W        = SUM_W + 1;
    localparam int MUL_W      = D_W + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int DIST_W     = 2 * D_W + 1;

    localparam logic [SEC_W-1:0] OCT_ENE = 3'd0;
    localparam logic [SEC_W-1:0] OCT_NNE = 3'd1;
    localparam logic [SEC_W-1:0] OCT_NNW = 3'd2;
    localparam logic [SEC_W-1:0] OCT_WNW = 3'd3;
    localparam logic [SEC_W-1:0] OCT_WSW = 3'd4;
    localparam logic [SEC_W-1:0] OCT_SSW = 3'd5;
    localparam logic [SEC_W-1:0] OCT_SSE = 3'd6;
    localparam logic [SEC_W-1:0] OCT_ESE = 3'd7;

    typedef enum logic [7:0] {
        ST_LOAD = 8'b0000_0001,
        ST_READ = 8'b0000_0010,
        ST_MX   = 8'b0000_0100,
        ST_MY   = 8'b0000_1000,
        ST_SQX  = 8'b0001_0000,
        ST_SQY  = 8'b0010_0000,
        ST_CMP  = 8'b0100_0000,
        ST_EMIT = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic update;
        logic clear;
    } sec_ctrl_t;

endpackage

// ===== rtl/core/oepo_point_ram.sv =====
// Point store: one write port, one registered read port.
`timescale 1ns / 1ps

module oepo_point_ram
(
    input  logic                        clk,
    input  logic                        we,
    input  logic [oepo_pkg::ADDR_W-1:0] waddr,
    input  logic [oepo_pkg::PT_W-1:0]   wdata,
    input  logic [oepo_pkg::ADDR_W-1:0] raddr,
    output logic [oepo_pkg::PT_W-1:0]   rdata
);
    import oepo_pkg::*;

    logic [PT_W-1:0] mem [MAX_POINTS];
    logic [PT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/oepo_mul.sv =====
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps

module oepo_mul
(
    input  logic                               clk,
    input  logic signed [oepo_pkg::MUL_W-1:0]  a,
    input  logic signed [oepo_pkg::MUL_W-1:0]  b,
    output logic signed [oepo_pkg::PROD_W-1:0] prod
);
    import oepo_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/core/oepo_sector.sv =====
// Octant classification and per-octant farthest point table.
`timescale 1ns / 1ps

module oepo_sector
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  oepo_pkg::sec_ctrl_t                ctrl,
    input  logic signed [oepo_pkg::D_W-1:0]    dx,
    input  logic signed [oepo_pkg::D_W-1:0]    dy,
    input  logic        [oepo_pkg::DIST_W-1:0] sq_dist,
    input  logic        [oepo_pkg::PT_W-1:0]   point,
    input  logic        [oepo_pkg::SEC_W-1:0]  rd_sector,
    output logic        [oepo_pkg::SECTORS-1:0] found,
    output logic        [oepo_pkg::PT_W-1:0]   rd_point
);
    import oepo_pkg::*;

    logic [SECTORS-1:0] found_reg;
    logic [SECTORS-1:0] found_next;
    logic [DIST_W-1:0]  best_dist_reg [SECTORS];
    logic [PT_W-1:0]    best_point_reg [SECTORS];

    logic signed [D_W:0] dxe;
    logic signed [D_W:0] dye;
    logic signed [D_W:0] ndx;
    logic                in_sector;
    logic [SEC_W-1:0]    sec;
    logic                take;

    always_comb
    begin
        dxe       = {dx[D_W-1], dx};
        dye       = {dy[D_W-1], dy};
        ndx       = -dxe;
        in_sector = 1'b1;
        sec       = OCT_ENE;
        if (dye >= 0 && dxe > 0)
        begin
            sec = (dye < dxe) ? OCT_ENE : OCT_NNE;
        end
        else if (dye > 0 && dxe <= 0)
        begin
            sec = (dye > ndx) ? OCT_NNW : OCT_WNW;
        end
        else if (dye <= 0 && dxe < 0)
        begin
            sec = (dye > dxe) ? OCT_WSW : OCT_SSW;
        end
        else if (dye < 0 && dxe >= 0)
        begin
            sec = (dye < ndx) ? OCT_SSE : OCT_ESE;
        end
        else
        begin
            in_sector = 1'b0;
        end
    end

    // strict compare: earlier point keeps a tie
    assign take = ctrl.update && in_sector &&
                  (!found_reg[sec] || (sq_dist > best_dist_reg[sec]));

    always_comb
    begin
        found_next = found_reg;
        if (ctrl.clear)
        begin
            found_next = '0;
        end
        else if (take)
        begin
            found_next[sec] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= '0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_dist_reg[sec]  <= sq_dist;
            best_point_reg[sec] <= point;
        end
    end

    assign found    = found_reg;
    assign rd_point = best_point_reg[rd_sector];

endmodule

// ===== rtl/core/octant_extreme_point_outline.sv =====
// Top level: point loading, centroid pass sequencer and outline result output.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready) carries one point per beat; the beat with
//   end_of_set high closes the set. Up to 1024 points are stored; further points
//   are dropped and the results of that set carry overflowed.
//   While loading, in_ready is high and a point is taken every cycle.
//   After the closing beat, in_ready drops and a pass runs over the stored
//   points: per point, a RAM read, then four passes through the one
//   shared multiplier for N*x, N*y, dx^2, dy^2, then the octant compare.
//   Then octants 0 to 7 are scanned, one per cycle while the output is free,
//   emitting one beat per non-empty octant on out_valid/out_ready;
//   last_vertex marks the final beat.
//   A stalled receiver holds the scan; the final beat sits in the output
//   register while the next set loads.
//   Reset clears the count, sums, octant found flags and output valid; the point
//   RAM is not cleared.
module octant_extreme_point_outline
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [oepo_pkg::COORD_W-1:0] point_x,
    input  logic signed [oepo_pkg::COORD_W-1:0] point_y,
    input  logic                                end_of_set,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [oepo_pkg::COORD_W-1:0] hull_x,
    output logic signed [oepo_pkg::COORD_W-1:0] hull_y,
    output logic        [oepo_pkg::SEC_W-1:0]   sector,
    output logic                                last_vertex,
    output logic                                overflowed
);
    import oepo_pkg::*;

    state_t                    state_reg, state_next;
    logic        [CNT_W-1:0]   count_reg, count_next;
    logic signed [SUM_W-1:0]   sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0]   sum_y_reg, sum_y_next;
    logic                      ovf_reg, ovf_next;
    logic        [CNT_W-1:0]   idx_reg, idx_next;
    logic signed [D_W-1:0]     dx_reg, dx_next;
    logic signed [D_W-1:0]     dy_reg, dy_next;
    logic        [DIST_W-1:0]  acc_reg, acc_next;
    logic        [SEC_W-1:0]   emit_reg, emit_next;
    logic                      out_valid_reg, out_valid_next;
    logic        [PT_W-1:0]    out_point_reg, out_point_next;
    logic        [SEC_W-1:0]   out_sec_reg, out_sec_next;
    logic                      out_last_reg, out_last_next;
    logic                      out_ovf_reg, out_ovf_next;

    logic                      accept;
    logic                      store_ok;
    logic        [PT_W-1:0]    rd_data;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [D_W-1:0]     prod_d;
    logic        [D_W-1:0]     mag_x;
    logic        [D_W-1:0]     mag_y;
    logic        [DIST_W-1:0]  sq_dist;
    sec_ctrl_t                 sec_ctrl;
    logic        [SECTORS-1:0] found;
    logic        [PT_W-1:0]    best_point;
    logic        [SECTORS-1:0] higher;
    logic                      out_free;

    assign in_ready = (state_reg == ST_LOAD);
    assign accept   = in_valid && in_ready;
    assign store_ok = (count_reg < CNT_W'(MAX_POINTS));

    oepo_point_ram u_ram
    (
        .clk   (clk),
        .we    (accept && store_ok),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata ({point_x, point_y}),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    assign px = rd_data[PT_W-1 -: COORD_W];
    assign py = rd_data[COORD_W-1:0];

    assign mag_x = dx_reg[D_W-1] ? D_W'(-dx_reg) : D_W'(dx_reg);
    assign mag_y = dy_reg[D_W-1] ? D_W'(-dy_reg) : D_W'(dy_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MX:
            begin
                mul_a = MUL_W'(count_reg);
                mul_b = MUL_W'(px);
            end
            ST_MY:
            begin
                mul_a = MUL_W'(count_reg);
                mul_b = MUL_W'(py);
            end
            ST_SQX:
            begin
                mul_a = MUL_W'(mag_x);
                mul_b = MUL_W'(mag_x);
            end
            ST_SQY:
            begin
                mul_a = MUL_W'(mag_y);
                mul_b = MUL_W'(mag_y);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    oepo_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign prod_d  = prod[D_W-1:0];
    assign sq_dist = acc_reg + prod[DIST_W-1:0];

    oepo_sector u_sector
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (sec_ctrl),
        .dx        (dx_reg),
        .dy        (dy_reg),
        .sq_dist   (sq_dist),
        .point     (rd_data),
        .rd_sector (emit_reg),
        .found     (found),
        .rd_point  (best_point)
    );

    always_comb
    begin
        for (int j = 0; j < SECTORS; j++)
        begin
            higher[j] = found[j] && (SEC_W'(j) > emit_reg);
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        acc_next       = acc_reg;
        emit_next      = emit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_point_next = out_point_reg;
        out_sec_next   = out_sec_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        sec_ctrl       = '0;

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (store_ok)
                    begin
                        count_next = count_reg + CNT_W'(1);
                        sum_x_next = sum_x_reg + SUM_W'(point_x);
                        sum_y_next = sum_y_reg + SUM_W'(point_y);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (end_of_set)
                    begin
                        idx_next   = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_MX;
            end
            ST_MX:
            begin
                state_next = ST_MY;
            end
            ST_MY:
            begin
                dx_next    = prod_d - D_W'(sum_x_reg);
                state_next = ST_SQX;
            end
            ST_SQX:
            begin
                dy_next    = prod_d - D_W'(sum_y_reg);
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                acc_next   = prod[DIST_W-1:0];
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                sec_ctrl.update = 1'b1;
                idx_next        = idx_reg + CNT_W'(1);
                if (idx_next == count_reg)
                begin
                    emit_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (found[emit_reg])
                    begin
                        out_valid_next = 1'b1;
                        out_point_next = best_point;
                        out_sec_next   = emit_reg;
                        out_last_next  = (higher == '0);
                        out_ovf_next   = ovf_reg;
                    end
                    emit_next = emit_reg + SEC_W'(1);
                    if (emit_reg == SEC_W'(SECTORS - 1))
                    begin
                        sec_ctrl.clear = 1'b1;
                        count_next     = '0;
                        sum_x_next     = '0;
                        sum_y_next     = '0;
                        ovf_next       = 1'b0;
                        state_next     = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        acc_reg       <= acc_next;
        out_point_reg <= out_point_next;
        out_sec_reg   <= out_sec_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign out_valid   = out_valid_reg;
    assign hull_x      = out_point_reg[PT_W-1 -: COORD_W];
    assign hull_y      = out_point_reg[COORD_W-1:0];
    assign sector      = out_sec_reg;
    assign last_vertex = out_last_reg;
    assign overflowed  = out_ovf_reg;

endmodule
